[src/tdc_pkg.sv]
package tdc_pkg;

  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TpsW     = 8;
  localparam int unsigned HpdW     = 7;
  localparam int unsigned SecW     = 6;
  localparam int unsigned MinW     = 6;
  localparam int unsigned HourW    = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_TICK = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_KEY1 = 2'd2,
    REQ_KEY2 = 2'd3
  } req_type_e;

  typedef enum logic {
    OUT_LED = 1'b0,
    OUT_TX  = 1'b1
  } out_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TPS = 1'b0,
    REG_HPD = 1'b1
  } reg_idx_e;

  localparam logic [3:0] CmdLedNibble = 4'hA;
  localparam logic [3:0] CmdReport    = 4'hB;

  localparam logic [ByteW-1:0] LedKey1Mask = 8'h40;
  localparam logic [ByteW-1:0] LedKey2Mask = 8'h80;
  localparam logic [ByteW-1:0] LedReset    = 8'hFF;

  localparam logic [TpsW-1:0] TpsReset     = 8'd20;
  localparam logic [HpdW-1:0] HpdReset     = 7'd24;
  localparam logic [SecW:0]   SecPerMin    = 7'd60;
  localparam logic [MinW:0]   MinPerHour   = 7'd60;

  typedef struct packed {
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
  } time_t;

  // Packed BCD of a value below 128; tens = v / 10 via a reciprocal multiply
  // (205 / 2048), exact for this range. Tens digit is kept to 4 bits.
  function automatic logic [ByteW-1:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

[src/tdc_req_if.sv]
interface tdc_req_if;
  import tdc_pkg::*;

  logic      valid;
  logic      ready;
  req_type_e req_type;
  logic [ByteW-1:0] cmd_byte;

  modport source(output valid, req_type, cmd_byte, input ready);
  modport sink(input valid, req_type, cmd_byte, output ready);
endinterface

[src/tdc_rsp_if.sv]
interface tdc_rsp_if;
  import tdc_pkg::*;

  logic      valid;
  logic      ready;
  out_kind_e out_kind;
  logic [ByteW-1:0] led_pattern;
  logic [ByteW-1:0] tx_byte;
  logic      last;

  modport source(output valid, out_kind, led_pattern, tx_byte, last, input ready);
  modport sink(input valid, out_kind, led_pattern, tx_byte, last, output ready);
endinterface

[src/tdc_clock.sv]
module tdc_clock (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [tdc_pkg::TpsW-1:0]  tps_i,
  input  logic [tdc_pkg::HpdW-1:0]  hpd_i,
  output tdc_pkg::time_t            time_o
);
  import tdc_pkg::*;

  logic [TpsW-1:0] tick_q, tick_d;
  time_t           time_q, time_d;
  logic [TpsW:0]   tick_inc;
  logic [SecW:0]   sec_inc;
  logic [MinW:0]   min_inc;
  logic [HourW:0]  hour_inc;

  assign tick_inc = {1'b0, tick_q} + 1'b1;
  assign sec_inc  = {1'b0, time_q.seconds} + 1'b1;
  assign min_inc  = {1'b0, time_q.minutes} + 1'b1;
  assign hour_inc = {1'b0, time_q.hours} + 1'b1;

  // Prescaler then seconds/minutes/hours ripple; a zero limit acts like one.
  always_comb begin
    tick_d = tick_q;
    time_d = time_q;
    if (adv_i) begin
      if (tick_inc >= {1'b0, tps_i}) begin
        tick_d = '0;
        if (sec_inc >= SecPerMin) begin
          time_d.seconds = '0;
          if (min_inc >= MinPerHour) begin
            time_d.minutes = '0;
            if (hour_inc >= {1'b0, hpd_i}) begin
              time_d.hours = '0;
            end else begin
              time_d.hours = hour_inc[HourW-1:0];
            end
          end else begin
            time_d.minutes = min_inc[MinW-1:0];
          end
        end else begin
          time_d.seconds = sec_inc[SecW-1:0];
        end
      end else begin
        tick_d = tick_inc[TpsW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      time_q <= '0;
    end else begin
      tick_q <= tick_d;
      time_q <= time_d;
    end
  end

  assign time_o = time_q;

endmodule

[src/time_of_day_clock_with_commands.sv]
// Time-of-day clock with serial commands and an active-low LED register.
//
// Channels: req (sink) carries one beat per event: a prescaler tick, a
// received command byte, or one of two key presses. rsp (source) carries
// result beats: LED pattern updates and packed-BCD time bytes, with last
// marking the final beat of each request. cfg_we_i/cfg_idx_i/cfg_data_i
// write ticks_per_second (index 0) and hours_per_day (index 1).
//
// An LED or report command, or a key press, accepted at one edge shows its
// first result beat in the next cycle; ticks give no beat. Throughput: one
// request per cycle while results drain; a time report (command 0xBn) holds
// three beats in the result buffer, so req.ready stays low until the last of
// them is being taken. req.ready is set by that three-entry buffer and rsp.ready.
//
// Reset: time and prescaler clear to zero, LEDs read 0xFF (all off), limits
// return to 20 ticks per second and 24 hours per day, result buffer empties.
// When the receiver stalls, the head beat holds and new requests wait.
module time_of_day_clock_with_commands (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tdc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tdc_pkg::CfgDataW-1:0]  cfg_data_i,
  tdc_req_if.sink                       req,
  tdc_rsp_if.source                     rsp
);
  import tdc_pkg::*;

  // Configuration registers.
  logic [TpsW-1:0] tps_q;
  logic [HpdW-1:0] hpd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
      hpd_q <= HpdReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_TPS: tps_q <= cfg_data_i[TpsW-1:0];
        REG_HPD: hpd_q <= cfg_data_i[HpdW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake bookkeeping. The result buffer holds up to three beats; a new
  // request is taken only when the buffer is empty or its last beat leaves
  // now, so LED state never moves under a pending beat.
  logic [1:0] cnt_q, cnt_d;
  logic       in_fire;
  logic       out_fire;

  assign out_fire  = rsp.valid && rsp.ready;
  assign req.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && rsp.ready);
  assign in_fire   = req.valid && req.ready;

  // Decode the accepted request.
  logic adv;
  logic is_led_cmd;
  logic is_report;

  assign adv        = in_fire && (req.req_type == REQ_TICK);
  assign is_led_cmd = (req.req_type == REQ_CMD) && (req.cmd_byte[7:4] == CmdLedNibble);
  assign is_report  = (req.req_type == REQ_CMD) && (req.cmd_byte[7:4] == CmdReport);

  time_t now;

  tdc_clock u_clock (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .tps_i  (tps_q),
    .hpd_i  (hpd_q),
    .time_o (now)
  );

  // LED register and result buffer load.
  logic [ByteW-1:0] led_q, led_d;
  out_kind_e        kind_q, kind_d;
  logic [ByteW-1:0] bytes_q [3];
  logic [ByteW-1:0] bytes_d [3];

  always_comb begin
    led_d   = led_q;
    cnt_d   = cnt_q;
    kind_d  = kind_q;
    bytes_d = bytes_q;

    // Drain: advance the buffer by one beat.
    if (out_fire) begin
      cnt_d      = cnt_q - 2'd1;
      bytes_d[0] = bytes_q[1];
      bytes_d[1] = bytes_q[2];
    end

    if (in_fire) begin
      case (req.req_type)
        REQ_CMD: begin
          if (is_led_cmd) begin
            led_d      = {led_q[7:4], ~req.cmd_byte[3:0]};
            cnt_d      = 2'd1;
            kind_d     = OUT_LED;
            bytes_d[0] = '0;
          end else if (is_report) begin
            cnt_d      = 2'd3;
            kind_d     = OUT_TX;
            bytes_d[0] = to_bcd(now.hours);
            bytes_d[1] = to_bcd({1'b0, now.minutes});
            bytes_d[2] = to_bcd({1'b0, now.seconds});
          end
        end
        REQ_KEY1: begin
          led_d      = led_q ^ LedKey1Mask;
          cnt_d      = 2'd1;
          kind_d     = OUT_LED;
          bytes_d[0] = '0;
        end
        REQ_KEY2: begin
          led_d      = led_q ^ LedKey2Mask;
          cnt_d      = 2'd1;
          kind_d     = OUT_LED;
          bytes_d[0] = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      led_q <= LedReset;
    end else begin
      cnt_q <= cnt_d;
      led_q <= led_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    bytes_q <= bytes_d;
  end

  // Result beat: head of the buffer, LED register as it stands.
  assign rsp.valid       = (cnt_q != 2'd0);
  assign rsp.out_kind    = kind_q;
  assign rsp.led_pattern = led_q;
  assign rsp.tx_byte     = bytes_q[0];
  assign rsp.last        = (cnt_q == 2'd1);

endmodule

[tb/sv/time_of_day_clock_with_commands_tb.sv]
module time_of_day_clock_with_commands_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdc_pkg::*;

  // Hard stop for a hung run. The slowest clean run is dominated by the 100-hour tick run.
  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned ItemsPerPhase = 70;   // four random phases
  localparam int unsigned HoldCycles    = 300;  // long receiver hold-off
  localparam int unsigned FlatOutReps   = 50;   // longer tick runs go without gaps
  localparam int unsigned NumDirRows    = 32;

  // One expected result beat, as it should show up on the rsp channel.
  typedef struct packed {
    out_kind_e        kind;
    logic [ByteW-1:0] led;
    logic [ByteW-1:0] tx;
    logic             last;
  } rsp_beat_t;

  // Directed stimulus: either a run of identical request beats or a register
  // write. Where typed is set, the expected beats are given in the row:
  // t_led for every beat, t_tx as hours/minutes/seconds for a time report.
  typedef enum bit {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    req_type_e        rt;
    logic [ByteW-1:0] cmd;
    logic [19:0]      reps;
    reg_idx_e         idx;
    logic [ByteW-1:0] data;
    logic             typed;
    logic [ByteW-1:0] t_led;
    logic [23:0]      t_tx;
  } dir_row_t;

  localparam dir_row_t DirTable [NumDirRows] = '{
    // Straight out of reset: 00:00:00, all LEDs off
    '{ROW_ITEM, REQ_CMD,  8'hB0, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'hFF, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'h00, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    // LED nibble commands, both extremes of the nibble
    '{ROW_ITEM, REQ_CMD,  8'hA0, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'hFF, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hAF, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'hF0, 24'h000000},
    // Keys flip bit 6 and bit 7
    '{ROW_ITEM, REQ_KEY1, 8'h00, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'hB0, 24'h000000},
    '{ROW_ITEM, REQ_KEY2, 8'hFF, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'h30, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hA5, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'h3A, 24'h000000},
    // Bytes outside both command groups do nothing
    '{ROW_ITEM, REQ_CMD,  8'hFF, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'h5A, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    // One tick short of a second at the reset prescale of 20
    '{ROW_ITEM, REQ_TICK, 8'h00, 20'd19,     REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hBF, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'h3A, 24'h000000},
    '{ROW_ITEM, REQ_TICK, 8'h00, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hB7, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'h3A, 24'h000001},
    // Prescaler already past a lowered limit: next tick rolls over
    '{ROW_REG,  REQ_TICK, 8'h00, 20'd0,      REG_TPS, 8'hFF, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_TICK, 8'h00, 20'd10,     REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_REG,  REQ_TICK, 8'h00, 20'd0,      REG_TPS, 8'h03, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_TICK, 8'h00, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hB2, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    // Zero ticks per second acts like one
    '{ROW_REG,  REQ_TICK, 8'h00, 20'd0,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_TICK, 8'h00, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    // Run 100 hours at one tick per second to push hours past 99
    '{ROW_REG,  REQ_TICK, 8'h00, 20'd0,      REG_TPS, 8'h01, 1'b0, 8'h00, 24'h000000},
    '{ROW_REG,  REQ_TICK, 8'h00, 20'd0,      REG_HPD, 8'h7F, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_TICK, 8'h00, 20'd360000, REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hB0, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'h3A, 24'hA00003},
    // Lowered day length leaves the hour alone until it next advances
    '{ROW_REG,  REQ_TICK, 8'h00, 20'd0,      REG_HPD, 8'h02, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hB4, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_KEY2, 8'h00, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'hBA, 24'h000000},
    '{ROW_ITEM, REQ_TICK, 8'h00, 20'd3600,   REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hB1, 20'd1,      REG_TPS, 8'h00, 1'b1, 8'hBA, 24'h000003},
    // Zero hours per day acts like one
    '{ROW_REG,  REQ_TICK, 8'h00, 20'd0,      REG_HPD, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_TICK, 8'h00, 20'd3600,   REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000},
    '{ROW_ITEM, REQ_CMD,  8'hBE, 20'd1,      REG_TPS, 8'h00, 1'b0, 8'h00, 24'h000000}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tdc_req_if req_ch ();
  tdc_rsp_if rsp_ch ();

  time_of_day_clock_with_commands uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // Clock model state and its copy of the two limit registers.
  logic [TpsW-1:0]  m_tps;
  logic [HpdW-1:0]  m_hpd;
  logic [TpsW-1:0]  m_ticks;
  logic [SecW-1:0]  m_sec;
  logic [MinW-1:0]  m_min;
  logic [HourW-1:0] m_hour;
  logic [ByteW-1:0] m_led;

  rsp_beat_t   pending_beats [$];  // expected result beats, oldest first
  rsp_beat_t   exp_beat;
  int unsigned err_count;
  int unsigned beat_num;

  bit          req_up;       // valid is currently being held high
  logic        smooth;       // both sides run without idling
  logic        rsp_hold;     // long receiver hold-off in progress
  bit          pressure_go;  // kick off the hold-off
  int unsigned rsp_stall_left;
  int unsigned rsp_roll;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ByteW-1:0] bcd_byte(input int unsigned v);
    // Tens digit only keeps four bits, which matters past 99 hours.
    return {4'((v / 10) & 15), 4'(v % 10)};
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // Apply one accepted request to the clock model and, if asked, queue the
  // beats it should produce.
  task automatic step_clock_model(input req_type_e rt, input logic [ByteW-1:0] cmd,
                                  input bit enqueue);
    rsp_beat_t   made [3];
    int unsigned n;
    n = 0;
    case (rt)
      REQ_TICK: begin
        // Carry chain: prescaler, seconds, minutes, hours.
        if (int'(m_ticks) + 1 >= int'(m_tps)) begin
          m_ticks = '0;
          if (int'(m_sec) + 1 >= int'(SecPerMin)) begin
            m_sec = '0;
            if (int'(m_min) + 1 >= int'(MinPerHour)) begin
              m_min = '0;
              if (int'(m_hour) + 1 >= int'(m_hpd)) m_hour = '0;
              else m_hour = m_hour + 1'b1;
            end else begin
              m_min = m_min + 1'b1;
            end
          end else begin
            m_sec = m_sec + 1'b1;
          end
        end else begin
          m_ticks = m_ticks + 1'b1;
        end
      end
      REQ_CMD: begin
        if (cmd[7:4] == CmdLedNibble) begin
          m_led   = {m_led[7:4], ~cmd[3:0]};
          made[0] = '{OUT_LED, m_led, 8'h00, 1'b1};
          n = 1;
        end else if (cmd[7:4] == CmdReport) begin
          made[0] = '{OUT_TX, m_led, bcd_byte(m_hour), 1'b0};
          made[1] = '{OUT_TX, m_led, bcd_byte(m_min), 1'b0};
          made[2] = '{OUT_TX, m_led, bcd_byte(m_sec), 1'b1};
          n = 3;
        end
      end
      REQ_KEY1: begin
        m_led   = m_led ^ LedKey1Mask;
        made[0] = '{OUT_LED, m_led, 8'h00, 1'b1};
        n = 1;
      end
      default: begin
        m_led   = m_led ^ LedKey2Mask;
        made[0] = '{OUT_LED, m_led, 8'h00, 1'b1};
        n = 1;
      end
    endcase
    if (enqueue) begin
      for (int unsigned k = 0; k < n; k++) pending_beats.push_back(made[k]);
    end
  endtask

  // Drop valid if it is still up from the last beat.
  task automatic idle_req();
    if (req_up) req_ch.valid <= 1'b0;
    req_up = 1'b0;
  endtask

  // Offer one request beat, hold it until taken, then update the model.
  task automatic send_req(input req_type_e rt, input logic [ByteW-1:0] cmd,
                          input bit may_idle, input bit predicted);
    int unsigned gap;
    int unsigned roll;
    gap = 0;
    if (may_idle && !smooth) begin
      // Mostly back to back, often a short gap, now and then a long one.
      roll = $urandom_range(99);
      if (roll >= 95)      gap = $urandom_range(40, 10);
      else if (roll >= 60) gap = $urandom_range(3, 1);
    end
    if (gap != 0) begin
      idle_req();
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.cmd_byte <= cmd;
    req_up = 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    step_clock_model(rt, cmd, predicted);
  endtask

  // Write one limit register with the block idle. Ticks leave nothing to
  // wait for, so give the pipe a few cycles once the queue is empty.
  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    idle_req();
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_TPS) m_tps = val[TpsW-1:0];
    else m_hpd = val[HpdW-1:0];
  endtask

  // Receiver: random ready with short and long stalls, forced low during
  // the hold-off, always high in the smooth phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_hold) begin
      rsp_ch.ready <= 1'b0;
    end else if (smooth) begin
      rsp_ch.ready <= 1'b1;
    end else if (rsp_stall_left != 0) begin
      rsp_stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_roll = $urandom_range(99);
      if (rsp_roll < 3) begin
        rsp_stall_left = $urandom_range(40, 15);
        rsp_ch.ready <= 1'b0;
      end else if (rsp_roll < 25) begin
        rsp_stall_left = $urandom_range(2, 0);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Hold the receiver off for a long stretch so the result buffer fills and
  // req.ready drops while the sender keeps offering.
  initial begin
    rsp_hold = 1'b0;
    wait (pressure_go);
    repeat (5) @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  // Checker: every result beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      beat_num++;
      if (pending_beats.size() == 0) begin
        note_error($sformatf("beat %0d unexpected: kind %0d led %02h tx %02h last %0d",
                             beat_num, rsp_ch.out_kind, rsp_ch.led_pattern,
                             rsp_ch.tx_byte, rsp_ch.last));
      end else begin
        exp_beat = pending_beats.pop_front();
        if (rsp_ch.out_kind !== exp_beat.kind)
          note_error($sformatf("beat %0d out_kind exp %0d got %0d",
                               beat_num, exp_beat.kind, rsp_ch.out_kind));
        if (rsp_ch.led_pattern !== exp_beat.led)
          note_error($sformatf("beat %0d led_pattern exp %02h got %02h",
                               beat_num, exp_beat.led, rsp_ch.led_pattern));
        if (rsp_ch.tx_byte !== exp_beat.tx)
          note_error($sformatf("beat %0d tx_byte exp %02h got %02h",
                               beat_num, exp_beat.tx, rsp_ch.tx_byte));
        if (rsp_ch.last !== exp_beat.last)
          note_error($sformatf("beat %0d last exp %0d got %0d",
                               beat_num, exp_beat.last, rsp_ch.last));
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("time_of_day_clock_with_commands_tb: done, errors");
    $finish;
  end

  initial begin
    dir_row_t         row;
    req_type_e        rt;
    logic [ByteW-1:0] cmd;
    int unsigned      tick_pct;
    int unsigned      roll;
    int unsigned      w;

    // Known values on the reset, config and request inputs from time zero.
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_TPS;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.cmd_byte = '0;
    smooth          = 1'b0;
    pressure_go     = 1'b0;
    req_up          = 1'b0;
    rsp_stall_left  = 0;
    err_count       = 0;
    beat_num        = 0;

    m_tps   = TpsReset;
    m_hpd   = HpdReset;
    m_ticks = '0;
    m_sec   = '0;
    m_min   = '0;
    m_hour  = '0;
    m_led   = LedReset;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: walk the table. Typed rows queue their beats from the
    // table; the model still runs so it stays in step.
    for (int unsigned r = 0; r < NumDirRows; r++) begin
      row = DirTable[r];
      if (row.kind == ROW_REG) begin
        write_reg(row.idx, row.data);
      end else begin
        for (int unsigned i = 0; i < row.reps; i++)
          send_req(row.rt, row.cmd, row.reps <= FlatOutReps, !row.typed);
        if (row.typed) begin
          if (row.rt == REQ_CMD && row.cmd[7:4] == CmdReport) begin
            pending_beats.push_back('{OUT_TX, row.t_led, row.t_tx[23:16], 1'b0});
            pending_beats.push_back('{OUT_TX, row.t_led, row.t_tx[15:8], 1'b0});
            pending_beats.push_back('{OUT_TX, row.t_led, row.t_tx[7:0], 1'b1});
          end else begin
            pending_beats.push_back('{OUT_LED, row.t_led, 8'h00, 1'b1});
          end
        end
      end
    end

    // Random part: four phases, each with its own limits.
    for (int unsigned ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TPS, 8'd1);
          write_reg(REG_HPD, 8'd99);
        end
        1: begin
          write_reg(REG_TPS, 8'd255);
          write_reg(REG_HPD, 8'd1);
        end
        2: begin
          write_reg(REG_TPS, 8'($urandom_range(8, 1)));
          write_reg(REG_HPD, 8'($urandom_range(99, 1)));
        end
        default: begin
          write_reg(REG_TPS, 8'($urandom_range(255)));
          write_reg(REG_HPD, 8'($urandom_range(127)));
        end
      endcase
      // Phase 2 runs with no idling on either side.
      smooth <= (ph == 2);
      @(posedge clk_i);
      // Phase 0 is tick-heavy and carries the long receiver hold-off.
      tick_pct = (ph == 0) ? 60 : 35;
      if (ph == 0) pressure_go = 1'b1;
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        roll = $urandom_range(99);
        cmd  = 8'($urandom_range(255));
        if (roll < tick_pct)                         rt = REQ_TICK;
        else if (roll < tick_pct + (100 - tick_pct) / 2) rt = REQ_CMD;
        else if (roll < 90)                          rt = REQ_KEY1;
        else                                         rt = REQ_KEY2;
        // Steer most command bytes into the two live groups.
        if (rt == REQ_CMD) begin
          roll = $urandom_range(99);
          if (roll < 40)      cmd[7:4] = CmdLedNibble;
          else if (roll < 75) cmd[7:4] = CmdReport;
        end
        send_req(rt, cmd, 1'b1, 1'b1);
      end
    end

    // Drain, give the block a few cycles to settle, then report.
    idle_req();
    smooth <= 1'b1;
    for (w = 0; w < 5000 && pending_beats.size() != 0; w++) @(posedge clk_i);
    if (pending_beats.size() != 0)
      note_error($sformatf("%0d expected beats never arrived", pending_beats.size()));
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("time_of_day_clock_with_commands_tb: done, clean");
    end else begin
      $display("time_of_day_clock_with_commands_tb: done, errors");
    end
    $finish;
  end

endmodule
